/* design/lsdf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spring-damper force unit: shared definitions
// Word formats, derived widths, register indexes and the structures that
// travel between the pipeline sections.
// ----------------------------------------------------------------------------
package lsdf_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int UNIT_FRAC = 30;
   localparam int REST_BITS = WORD_BITS - 1;
   localparam int LANES     = 3;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_X  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_Y  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_Z  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_STIFFNESS = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPER    = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_REST_LEN  = CSR_IDX_W'(5);

   // Offset from anchor, its square sum and the integer root.
   localparam int D_W    = WORD_BITS + 1;
   localparam int SQ_W   = 2 * D_W;
   localparam int ROOT_W = D_W;
   localparam int REM_W  = ROOT_W + 2;
   // Direction quotient: |d| scaled by 2^UNIT_FRAC over the length.
   localparam int NUM_W  = D_W + UNIT_FRAC;
   localparam int QUO_W  = UNIT_FRAC + 1;
   localparam int U_W    = QUO_W + 1;

   typedef struct packed {
      logic [LANES-1:0][D_W-1:0]       d_mag;
      logic [LANES-1:0]                d_neg;
      logic [LANES-1:0][WORD_BITS-1:0] vel;
   } lsdf_geo_type;

   typedef struct packed {
      logic [LANES-1:0]                d_neg;
      logic [LANES-1:0][WORD_BITS-1:0] vel;
      logic [ROOT_W-1:0]               len;
   } lsdf_dside_type;

   typedef struct packed {
      logic [LANES-1:0][U_W-1:0]       dir;
      logic [LANES-1:0][WORD_BITS-1:0] vel;
      logic [ROOT_W-1:0]               len;
   } lsdf_dir_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] stiffness;
      logic [WORD_BITS-1:0] damper;
      logic [REST_BITS-1:0] rest;
   } lsdf_cfg_type;

endpackage

/* design/linear_spring_damper_force_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear spring-damper force unit
// Restraint force of a spring and damper between a fixed anchor and a
// moving attachment point, all in signed Q16.16.
//
// The request channel carries one word per attachment sample: position and
// velocity on three axes. The response channel returns one force word per
// request, in order. The user writes anchor, stiffness, damping and rest
// length through the csr port only while no word is in flight; not enforced.
//
// The pipeline takes a word every cycle unless a waiting response holds it.
// Most of the path from request to response is the 33-stage square root
// and the 31-stage direction divider, one bit per stage each.
// The whole pipeline advances together: while a finished response waits
// on rsp_ready the pipeline holds and req_ready is low, and nothing is
// lost or repeated. Reset empties the pipeline and clears the registers.
// ----------------------------------------------------------------------------
module linear_spring_damper_force_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [lsdf_pkg::WORD_BITS-1:0]    req_pos_x,
   input  logic signed [lsdf_pkg::WORD_BITS-1:0]    req_pos_y,
   input  logic signed [lsdf_pkg::WORD_BITS-1:0]    req_pos_z,
   input  logic signed [lsdf_pkg::WORD_BITS-1:0]    req_vel_x,
   input  logic signed [lsdf_pkg::WORD_BITS-1:0]    req_vel_y,
   input  logic signed [lsdf_pkg::WORD_BITS-1:0]    req_vel_z,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [lsdf_pkg::WORD_BITS-1:0]    rsp_force_x,
   output logic signed [lsdf_pkg::WORD_BITS-1:0]    rsp_force_y,
   output logic signed [lsdf_pkg::WORD_BITS-1:0]    rsp_force_z,
   input  logic                                     csr_write_en,
   input  logic [lsdf_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [lsdf_pkg::WORD_BITS-1:0]           csr_wdata
);
   import lsdf_pkg::*;

   logic adv;

   logic [LANES-1:0][WORD_BITS-1:0] anchor_ff;
   lsdf_cfg_type                    cfg_ff;

   logic [LANES-1:0][WORD_BITS-1:0] pos_w, vel_w;

   logic                            st_a_vld_ff, st_b_vld_ff, st_c_vld_ff, st_d_vld_ff;
   logic [LANES-1:0][D_W-1:0]       st_a_d_ff;
   logic [LANES-1:0][WORD_BITS-1:0] st_a_v_ff;
   lsdf_geo_type                    st_b_geo_ff, st_b_geo_in;
   lsdf_geo_type                    st_c_geo_ff, st_d_geo_ff;
   logic [SQ_W-1:0]                 st_c_sq_ff [LANES], st_c_sq_in [LANES];
   logic [SQ_W-1:0]                 st_d_sum_ff;

   logic                            sq_valid;
   logic [ROOT_W-1:0]               sq_root;
   lsdf_geo_type                    sq_geo;

   logic                            dv_valid;
   logic [LANES-1:0][QUO_W-1:0]     dv_quo;
   lsdf_dside_type                  dv_side;

   logic                            st_u_vld_ff;
   lsdf_dir_type                    st_u_dir_ff, st_u_dir_in;

   logic                            f_valid;
   logic [LANES-1:0][WORD_BITS-1:0] f_force;

   logic                            rsp_valid_ff;
   logic [LANES-1:0][WORD_BITS-1:0] rsp_force_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   assign pos_w = {req_pos_z, req_pos_y, req_pos_x};
   assign vel_w = {req_vel_z, req_vel_y, req_vel_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_ff <= '0;
         cfg_ff    <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ANCHOR_X:  anchor_ff[0]     <= csr_wdata;
            CSR_ANCHOR_Y:  anchor_ff[1]     <= csr_wdata;
            CSR_ANCHOR_Z:  anchor_ff[2]     <= csr_wdata;
            CSR_STIFFNESS: cfg_ff.stiffness <= csr_wdata;
            CSR_DAMPER:    cfg_ff.damper    <= csr_wdata;
            CSR_REST_LEN:  cfg_ff.rest      <= csr_wdata[REST_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         st_b_geo_in.d_neg[i] = st_a_d_ff[i][D_W-1];
         st_b_geo_in.d_mag[i] = st_a_d_ff[i][D_W-1] ? D_W'(0) - st_a_d_ff[i] : st_a_d_ff[i];
         st_b_geo_in.vel[i]   = st_a_v_ff[i];
         st_c_sq_in[i]        = st_b_geo_ff.d_mag[i] * st_b_geo_ff.d_mag[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_a_vld_ff <= 1'b0;
         st_b_vld_ff <= 1'b0;
         st_c_vld_ff <= 1'b0;
         st_d_vld_ff <= 1'b0;
      end else if (adv) begin
         st_a_vld_ff <= req_valid;
         st_b_vld_ff <= st_a_vld_ff;
         st_c_vld_ff <= st_b_vld_ff;
         st_d_vld_ff <= st_c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < LANES; i++) begin
            st_a_d_ff[i] <= {pos_w[i][WORD_BITS-1], pos_w[i]}
                          - {anchor_ff[i][WORD_BITS-1], anchor_ff[i]};
         end
         st_a_v_ff   <= vel_w;
         st_b_geo_ff <= st_b_geo_in;
         st_c_geo_ff <= st_b_geo_ff;
         st_c_sq_ff  <= st_c_sq_in;
         st_d_geo_ff <= st_c_geo_ff;
         st_d_sum_ff <= st_c_sq_ff[0] + st_c_sq_ff[1] + st_c_sq_ff[2];
      end
   end

   lsdf_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (st_d_vld_ff),
      .in_radicand (st_d_sum_ff),
      .in_geo      (st_d_geo_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_geo     (sq_geo)
   );

   lsdf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_len    (sq_root),
      .in_geo    (sq_geo),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // Signed direction; a zero length gives a zero direction and so no force.
   always_comb begin
      logic [U_W-1:0] q;
      for (int i = 0; i < LANES; i++) begin
         q = {1'b0, dv_quo[i]};
         if (dv_side.len == '0) begin
            st_u_dir_in.dir[i] = '0;
         end else if (dv_side.d_neg[i]) begin
            st_u_dir_in.dir[i] = U_W'(0) - q;
         end else begin
            st_u_dir_in.dir[i] = q;
         end
      end
      st_u_dir_in.vel = dv_side.vel;
      st_u_dir_in.len = dv_side.len;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_u_vld_ff <= 1'b0;
      end else if (adv) begin
         st_u_vld_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_u_dir_ff <= st_u_dir_in;
      end
   end

   lsdf_force u_force (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (st_u_vld_ff),
      .in_dir    (st_u_dir_ff),
      .cfg       (cfg_ff),
      .out_valid (f_valid),
      .out_force (f_force)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_force_ff <= f_force;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_force_x = rsp_force_ff[0];
   assign rsp_force_y = rsp_force_ff[1];
   assign rsp_force_z = rsp_force_ff[2];

endmodule

/* design/lsdf_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit restoring root, one result bit per stage, with the
// geometry of each word carried alongside.
// ----------------------------------------------------------------------------
module lsdf_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [lsdf_pkg::SQ_W-1:0]     in_radicand,
   input  lsdf_pkg::lsdf_geo_type        in_geo,
   output logic                          out_valid,
   output logic [lsdf_pkg::ROOT_W-1:0]   out_root,
   output lsdf_pkg::lsdf_geo_type        out_geo
);
   import lsdf_pkg::*;

   localparam int STAGES = ROOT_W;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic [SQ_W-1:0]   rad_ff [STAGES], rad_in [STAGES], rad_src [STAGES];
   logic [REM_W-1:0]  rem_ff [STAGES], rem_in [STAGES], rem_src [STAGES];
   logic [ROOT_W-1:0] root_ff [STAGES], root_in [STAGES], root_src [STAGES];
   lsdf_geo_type      geo_ff [STAGES], geo_in [STAGES];

   always_comb begin
      logic [REM_W+1:0] rem_sh;
      logic [REM_W+1:0] trial;
      rad_src[0]  = in_radicand;
      rem_src[0]  = '0;
      root_src[0] = '0;
      vld_in[0]   = in_valid;
      geo_in[0]   = in_geo;
      for (int k = 1; k < STAGES; k++) begin
         rad_src[k]  = rad_ff[k-1];
         rem_src[k]  = rem_ff[k-1];
         root_src[k] = root_ff[k-1];
         vld_in[k]   = vld_ff[k-1];
         geo_in[k]   = geo_ff[k-1];
      end
      for (int k = 0; k < STAGES; k++) begin
         // Bring down the next two radicand bits and try 4r + 1.
         rem_sh = {rem_src[k], rad_src[k][SQ_W-1 -: 2]};
         trial  = {2'b00, root_src[k], 2'b01};
         if (rem_sh >= trial) begin
            rem_in[k]  = REM_W'(rem_sh - trial);
            root_in[k] = {root_src[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem_sh[REM_W-1:0];
            root_in[k] = {root_src[k][ROOT_W-2:0], 1'b0};
         end
         rad_in[k] = {rad_src[k][SQ_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         geo_ff  <= geo_in;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_geo   = geo_ff[STAGES-1];

endmodule

/* design/lsdf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined direction divider
// Three restoring divider lanes, one quotient bit per stage, forming
// |d| * 2^UNIT_FRAC / length for each axis.
// ----------------------------------------------------------------------------
module lsdf_div (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               adv,
   input  logic                                               in_valid,
   input  logic [lsdf_pkg::ROOT_W-1:0]                        in_len,
   input  lsdf_pkg::lsdf_geo_type                             in_geo,
   output logic                                               out_valid,
   output logic [lsdf_pkg::LANES-1:0][lsdf_pkg::QUO_W-1:0]    out_quo,
   output lsdf_pkg::lsdf_dside_type                           out_side
);
   import lsdf_pkg::*;

   localparam int STAGES = QUO_W;
   localparam int DEN_W  = ROOT_W;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic [LANES-1:0][DEN_W-1:0] rem_ff [STAGES], rem_in [STAGES], rem_src [STAGES];
   logic [LANES-1:0][QUO_W-1:0] num_ff [STAGES], num_in [STAGES], num_src [STAGES];
   logic [LANES-1:0][QUO_W-1:0] quo_ff [STAGES], quo_in [STAGES], quo_src [STAGES];
   lsdf_dside_type side_ff [STAGES], side_in [STAGES];

   always_comb begin
      logic [NUM_W-1:0] numer;
      logic [DEN_W:0]   rem_sh;
      vld_in[0]        = in_valid;
      side_in[0].d_neg = in_geo.d_neg;
      side_in[0].vel   = in_geo.vel;
      side_in[0].len   = in_len;
      for (int i = 0; i < LANES; i++) begin
         // The quotient stays below 2^QUO_W, so the top bits start as remainder.
         numer            = {in_geo.d_mag[i], UNIT_FRAC'(0)};
         rem_src[0][i]    = {1'b0, numer[NUM_W-1:QUO_W]};
         num_src[0][i]    = numer[QUO_W-1:0];
         quo_src[0][i]    = '0;
      end
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k]  = vld_ff[k-1];
         side_in[k] = side_ff[k-1];
         rem_src[k] = rem_ff[k-1];
         num_src[k] = num_ff[k-1];
         quo_src[k] = quo_ff[k-1];
      end
      for (int k = 0; k < STAGES; k++) begin
         for (int i = 0; i < LANES; i++) begin
            rem_sh = {rem_src[k][i], num_src[k][i][QUO_W-1]};
            if (rem_sh >= {1'b0, side_in[k].len}) begin
               rem_in[k][i] = DEN_W'(rem_sh - {1'b0, side_in[k].len});
               quo_in[k][i] = {quo_src[k][i][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[k][i] = rem_sh[DEN_W-1:0];
               quo_in[k][i] = {quo_src[k][i][QUO_W-2:0], 1'b0};
            end
            num_in[k][i] = {num_src[k][i][QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         quo_ff  <= quo_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_quo   = quo_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

/* design/lsdf_force.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Force pipeline
// From the unit direction, velocity and length to the saturated force
// vector: spring and damper terms, their sum, and the scaling by direction.
// ----------------------------------------------------------------------------
module lsdf_force (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                adv,
   input  logic                                                in_valid,
   input  lsdf_pkg::lsdf_dir_type                              in_dir,
   input  lsdf_pkg::lsdf_cfg_type                              cfg,
   output logic                                                out_valid,
   output logic [lsdf_pkg::LANES-1:0][lsdf_pkg::WORD_BITS-1:0] out_force
);
   import lsdf_pkg::*;

   localparam int FSTAGES = 9;
   localparam int DIR_DEPTH = 6;
   localparam int E_W     = ROOT_W + 1;
   localparam int EMAG_W  = ROOT_W;
   localparam int KE_W    = WORD_BITS + EMAG_W;
   localparam int AMAG_W  = KE_W - FRAC_BITS;
   localparam int A_W     = AMAG_W + 1;
   localparam int P_W     = U_W + WORD_BITS;
   localparam int PMAG_W  = P_W - 1;
   localparam int PLO_W   = WORD_BITS;
   localparam int PHI_W   = PMAG_W - PLO_W;
   localparam int CPLO_W  = WORD_BITS + PLO_W;
   localparam int CPHI_W  = WORD_BITS + PHI_W;
   localparam int CP_W    = WORD_BITS + PMAG_W;
   localparam int BMAG_W  = CP_W - UNIT_FRAC - FRAC_BITS;
   localparam int S_W     = ((AMAG_W > BMAG_W) ? AMAG_W : BMAG_W) + 2;
   localparam int SMAG_W  = S_W - 1;
   localparam int SLO_W   = SMAG_W / 2;
   localparam int SHI_W   = SMAG_W - SLO_W;
   localparam int UMAG_W  = QUO_W;
   localparam int MLO_W   = SLO_W + UMAG_W;
   localparam int MHI_W   = SHI_W + UMAG_W;
   localparam int M_W     = SMAG_W + UMAG_W;
   localparam int FM_W    = M_W - UNIT_FRAC;

   logic [FSTAGES-1:0] fv_ff;
   logic [LANES-1:0][U_W-1:0] dir_ff [DIR_DEPTH];

   logic signed [P_W-1:0]  prod_ff [LANES], prod_in [LANES];
   logic signed [E_W-1:0]  e_ff, e_in;
   logic signed [P_W-1:0]  p_ff, p_in;
   logic [EMAG_W-1:0]      e_abs_ff, e_abs_in;
   logic                   e_neg_ff [2], e_neg_in;
   logic [PMAG_W-1:0]      p_abs_ff, p_abs_in;
   logic                   p_neg_ff [3], p_neg_in;
   logic [KE_W-1:0]        ke_ff, ke_in;
   logic [CPLO_W-1:0]      cplo_ff, cplo_in;
   logic [CPHI_W-1:0]      cphi_ff, cphi_in;
   logic signed [A_W-1:0]  a_ff [2], a_in;
   logic [BMAG_W-1:0]      bm_ff, bm_in;
   logic signed [S_W-1:0]  s_ff, s_in;
   logic [SMAG_W-1:0]      s_abs_ff, s_abs_in;
   logic [LANES-1:0]       neg_ff [3], neg_in;
   logic [UMAG_W-1:0]      uabs_ff [LANES], uabs_in [LANES];
   logic [MLO_W-1:0]       mlo_ff [LANES], mlo_in [LANES];
   logic [MHI_W-1:0]       mhi_ff [LANES], mhi_in [LANES];
   logic [FM_W-1:0]        fm_ff [LANES], fm_in [LANES];

   always_comb begin
      logic [CP_W-1:0]  cp;
      logic [M_W-1:0]   m;
      logic             s_pos;
      logic             u_neg;
      // Velocity projection terms and extension.
      for (int i = 0; i < LANES; i++) begin
         prod_in[i] = $signed(in_dir.dir[i]) * $signed(in_dir.vel[i]);
      end
      e_in = {1'b0, in_dir.len} - E_W'(cfg.rest);
      // Projection sum and extension magnitude.
      p_in     = prod_ff[0] + prod_ff[1] + prod_ff[2];
      e_neg_in = e_ff[E_W-1];
      e_abs_in = e_neg_in ? EMAG_W'(-e_ff) : EMAG_W'(e_ff);
      // Spring product.
      p_neg_in = p_ff[P_W-1];
      p_abs_in = p_neg_in ? PMAG_W'(-p_ff) : PMAG_W'(p_ff);
      ke_in    = cfg.stiffness * e_abs_ff;
      // Damper product in two halves; spring term truncated toward zero.
      cplo_in = cfg.damper * p_abs_ff[PLO_W-1:0];
      cphi_in = cfg.damper * p_abs_ff[PMAG_W-1:PLO_W];
      a_in    = e_neg_ff[1] ? A_W'(0) - A_W'(ke_ff[KE_W-1:FRAC_BITS])
                            : A_W'(ke_ff[KE_W-1:FRAC_BITS]);
      // Recombine the damper halves.
      cp    = {cphi_ff, PLO_W'(0)} + CP_W'(cplo_ff);
      bm_in = cp[CP_W-1:UNIT_FRAC+FRAC_BITS];
      // The damper term carries the sign of the projection.
      s_in = p_neg_ff[2] ? S_W'(a_ff[1]) - S_W'(bm_ff) : S_W'(a_ff[1]) + S_W'(bm_ff);
      // The force is -s times u, so its sign is that of s flipped, times that of u.
      s_pos    = !s_ff[S_W-1] && (s_ff != '0);
      s_abs_in = s_ff[S_W-1] ? SMAG_W'(-s_ff) : SMAG_W'(s_ff);
      for (int i = 0; i < LANES; i++) begin
         u_neg      = dir_ff[DIR_DEPTH-1][i][U_W-1];
         neg_in[i]  = s_pos ^ u_neg;
         uabs_in[i] = u_neg ? UMAG_W'(U_W'(0) - dir_ff[DIR_DEPTH-1][i])
                            : UMAG_W'(dir_ff[DIR_DEPTH-1][i]);
      end
      for (int i = 0; i < LANES; i++) begin
         mlo_in[i] = s_abs_ff[SLO_W-1:0] * uabs_ff[i];
         mhi_in[i] = s_abs_ff[SMAG_W-1:SLO_W] * uabs_ff[i];
      end
      for (int i = 0; i < LANES; i++) begin
         m        = {mhi_ff[i], SLO_W'(0)} + M_W'(mlo_ff[i]);
         fm_in[i] = m[M_W-1:UNIT_FRAC];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (adv) begin
         fv_ff <= {fv_ff[FSTAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dir_ff[0] <= in_dir.dir;
         for (int k = 1; k < DIR_DEPTH; k++) begin
            dir_ff[k] <= dir_ff[k-1];
         end
         prod_ff     <= prod_in;
         e_ff        <= e_in;
         p_ff        <= p_in;
         e_abs_ff    <= e_abs_in;
         e_neg_ff[0] <= e_neg_in;
         e_neg_ff[1] <= e_neg_ff[0];
         p_abs_ff    <= p_abs_in;
         p_neg_ff[0] <= p_neg_in;
         p_neg_ff[1] <= p_neg_ff[0];
         p_neg_ff[2] <= p_neg_ff[1];
         ke_ff       <= ke_in;
         cplo_ff     <= cplo_in;
         cphi_ff     <= cphi_in;
         a_ff[0]     <= a_in;
         a_ff[1]     <= a_ff[0];
         bm_ff       <= bm_in;
         s_ff        <= s_in;
         s_abs_ff    <= s_abs_in;
         neg_ff[0]   <= neg_in;
         neg_ff[1]   <= neg_ff[0];
         neg_ff[2]   <= neg_ff[1];
         uabs_ff     <= uabs_in;
         mlo_ff      <= mlo_in;
         mhi_ff      <= mhi_in;
         fm_ff       <= fm_in;
      end
   end

   // Saturate each component on its own; negative values reach one further.
   always_comb begin
      logic [FM_W-1:0] cap;
      logic [FM_W-1:0] sat;
      for (int i = 0; i < LANES; i++) begin
         cap = neg_ff[2][i] ? (FM_W'(1) << (WORD_BITS - 1))
                            : (FM_W'(1) << (WORD_BITS - 1)) - FM_W'(1);
         sat = (fm_ff[i] > cap) ? cap : fm_ff[i];
         out_force[i] = neg_ff[2][i] ? WORD_BITS'(0) - sat[WORD_BITS-1:0]
                                     : sat[WORD_BITS-1:0];
      end
   end

   assign out_valid = fv_ff[FSTAGES-1];

endmodule

/* design/lsdf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spring-damper force unit: port checker
// Watches the request and response handshakes of the top level.
// ----------------------------------------------------------------------------
module lsdf_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [lsdf_pkg::WORD_BITS-1:0] rsp_force_x,
   input logic signed [lsdf_pkg::WORD_BITS-1:0] rsp_force_y,
   input logic signed [lsdf_pkg::WORD_BITS-1:0] rsp_force_z
);

   // Reset empties the pipeline, so no response word follows it.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word valid straight after reset");

   // A response word that is not taken stays and does not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_force_x)
         && $stable(rsp_force_y) && $stable(rsp_force_z))
      else $error("stalled response word changed or vanished");

   // While a response word is held, the pipeline is frozen and takes nothing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request word taken while the pipeline is stalled");

   // With the output free, the pipeline is always ready for a new word.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request refused although the pipeline can advance");

   // A request is taken while a response word is valid only if that word is taken too.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_valid |-> rsp_ready)
      else $error("request word taken while a response word waits");

endmodule

bind linear_spring_damper_force_unit lsdf_checker u_lsdf_checker (.*);
